@@ rtl/rpa_pkg.sv @@
// Package for the 3D axis rotation block: widths, CORDIC constants, arctangent table.
// Used by every module in rtl/; no other dependencies.
package rpa_pkg;

  localparam int CordicStages = 16;
  localparam int InvGainQ30 = 652032874;

  // Widths of the internal data.
  localparam int CW = 34;   // CORDIC x/y, Q2.30 plus headroom
  localparam int ZW = 34;   // angle residual, 2^-32 turn units
  localparam int PW = 33;   // point minus pivot
  localparam int TW = 18;   // sine and cosine, Q16

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    zval_t z;
  } cstate_t;

  function automatic zval_t atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return zval_t'(v);
  endfunction

endpackage

@@ rtl/rpa_cordic_cell.sv @@
// One CORDIC micro-rotation cell with its stage register.
// Depends on rpa_pkg.
module rpa_cordic_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [4:0]          idx,
  input  rpa_pkg::cstate_t    d_in,
  output rpa_pkg::cstate_t    d_out
);

  rpa_pkg::cstate_t st_r, st_nxt;
  rpa_pkg::cval_t dx, dy;
  rpa_pkg::zval_t at;

  always_comb begin
    dx = d_in.y >>> idx;
    dy = d_in.x >>> idx;
    at = rpa_pkg::atan_turn(idx);
    if (!d_in.z[rpa_pkg::ZW-1]) begin
      st_nxt.x = d_in.x - dx;
      st_nxt.y = d_in.y + dy;
      st_nxt.z = d_in.z - at;
    end else begin
      st_nxt.x = d_in.x + dx;
      st_nxt.y = d_in.y - dy;
      st_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule

@@ rtl/rpa_rodrigues.sv @@
// Rodrigues combine pipeline: dot, cross, scaling, pivot add-back, saturation.
// Depends on rpa_pkg. All registers advance only while en is high.
module rpa_rodrigues (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [rpa_pkg::TW-1:0] cos_v,
  input  logic signed [rpa_pkg::TW-1:0] sin_v,
  input  logic signed [rpa_pkg::PW-1:0] p_x,
  input  logic signed [rpa_pkg::PW-1:0] p_y,
  input  logic signed [rpa_pkg::PW-1:0] p_z,
  input  logic signed [15:0]          k_x,
  input  logic signed [15:0]          k_y,
  input  logic signed [15:0]          k_z,
  input  logic signed [31:0]          v_x,
  input  logic signed [31:0]          v_y,
  input  logic signed [31:0]          v_z,
  output logic signed [31:0]          r_x,
  output logic signed [31:0]          r_y,
  output logic signed [31:0]          r_z
);

  localparam int TWX = rpa_pkg::TW;
  localparam int PWX = rpa_pkg::PW;

  // stage 1: nine axis*point products (49 bits each), c*p
  logic signed [48:0] kp_r [3][3];
  logic signed [51:0] cp_r [3];
  logic signed [TWX-1:0] c1_r, s1_r;
  logic signed [15:0] k1_r [3];
  logic signed [31:0] v1_r [3];

  // stage 2: dot, cross, cos terms
  logic signed [36:0] dot2_r;
  logic signed [37:0] q2_r [3];
  logic signed [36:0] ct2_r [3];
  logic signed [TWX-1:0] c2_r, s2_r;
  logic signed [15:0] k2_r [3];
  logic signed [31:0] v2_r [3];

  // stage 3: t and sin*q
  logic signed [38:0] t3_r;
  logic signed [39:0] st3_r [3];
  logic signed [36:0] ct3_r [3];
  logic signed [15:0] k3_r [3];
  logic signed [31:0] v3_r [3];

  // stage 4: k*t, sum, saturate
  logic signed [31:0] r4_r [3];

  logic signed [PWX-1:0] p_in [3];
  logic signed [15:0] k_in [3];
  logic signed [31:0] v_in [3];

  logic signed [50:0] dsum;
  logic signed [50:0] xs [3];
  logic signed [TWX:0] omc;
  logic signed [57:0] dprod;
  logic signed [57:0] sq [3];
  logic signed [56:0] kt [3];
  logic signed [60:0] tot [3];

  assign p_in[0] = p_x; assign p_in[1] = p_y; assign p_in[2] = p_z;
  assign k_in[0] = k_x; assign k_in[1] = k_y; assign k_in[2] = k_z;
  assign v_in[0] = v_x; assign v_in[1] = v_y; assign v_in[2] = v_z;

  always_comb begin
    dsum = 51'(kp_r[0][0]) + 51'(kp_r[1][1]) + 51'(kp_r[2][2]);
    xs[0] = 51'(kp_r[1][2]) - 51'(kp_r[2][1]);
    xs[1] = 51'(kp_r[2][0]) - 51'(kp_r[0][2]);
    xs[2] = 51'(kp_r[0][1]) - 51'(kp_r[1][0]);
    omc = (TWX+1)'(65536) - (TWX+1)'(c2_r);
    dprod = 58'(dot2_r) * 58'(omc);
    for (int j = 0; j < 3; j++) begin
      sq[j] = 58'(s2_r) * 58'(q2_r[j]);
      kt[j] = 57'(k3_r[j]) * 57'(t3_r);
      tot[j] = 61'(ct3_r[j]) + 61'(st3_r[j]) + 61'((kt[j] + 57'sd8192) >>> 14)
               + 61'(v3_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) kp_r[a][b] <= 49'(k_in[a]) * 49'(p_in[b]);
        cp_r[a] <= 52'(cos_v) * 52'(p_in[a]);
        k1_r[a] <= k_in[a];
        v1_r[a] <= v_in[a];
        k2_r[a] <= k1_r[a];
        v2_r[a] <= v1_r[a];
        q2_r[a] <= 38'((xs[a] + 51'sd8192) >>> 14);
        ct2_r[a] <= 37'((cp_r[a] + 52'sd32768) >>> 16);
        k3_r[a] <= k2_r[a];
        v3_r[a] <= v2_r[a];
        st3_r[a] <= 40'((sq[a] + 58'sd32768) >>> 16);
        ct3_r[a] <= ct2_r[a];
        if (tot[a] > 61'sd2147483647) r4_r[a] <= 32'sh7fffffff;
        else if (tot[a] < -61'sd2147483648) r4_r[a] <= 32'sh80000000;
        else r4_r[a] <= 32'(tot[a]);
      end
      c1_r <= cos_v;
      s1_r <= sin_v;
      c2_r <= c1_r;
      s2_r <= s1_r;
      dot2_r <= 37'((dsum + 51'sd8192) >>> 14);
      t3_r <= 39'((dprod + 58'sd32768) >>> 16);
    end
  end

  assign r_x = r4_r[0];
  assign r_y = r4_r[1];
  assign r_z = r4_r[2];

endmodule

@@ rtl/rotate_point_3d_about_axis.sv @@
// Rotates a Q16.16 point about a unit Q2.14 axis through a pivot by a binary angle.
// Top level; depends on rpa_pkg, rpa_cordic_cell and rpa_rodrigues.
// The block takes one beat per clock unless a stalled result blocks it, and holds no
// state between beats. A beat runs through an input register, a row of
// CordicStages CORDIC cells (one register each), then four combine stages. The
// whole pipeline advances together; a stall on the output freezes it, and the
// output register frees the input side whenever it is empty or being taken.
module rotate_point_3d_about_axis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [31:0] in_pivot_x,
  input  logic signed [31:0] in_pivot_y,
  input  logic signed [31:0] in_pivot_z,
  input  logic        [15:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_rotated_x,
  output logic signed [31:0] out_rotated_y,
  output logic signed [31:0] out_rotated_z
);

  localparam int NS = rpa_pkg::CordicStages;
  localparam int DEPTH = NS + 5;

  logic en;
  logic [DEPTH-1:0] vld_r;

  // Whole pipeline moves when its last slot is empty or being taken.
  assign en = !vld_r[DEPTH-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end

  // Stage 0: point minus pivot, quadrant fold, CORDIC seed.
  logic signed [rpa_pkg::PW-1:0] p0_r [3];
  logic signed [15:0] k0_r [3];
  logic signed [31:0] v0_r [3];
  logic flip0_r;
  rpa_pkg::cstate_t seed_r;
  logic fl;
  logic [15:0] a2;

  always_comb begin
    fl = (in_angle >= 16'd16384) && (in_angle < 16'd49152);
    a2 = fl ? (in_angle ^ 16'h8000) : in_angle;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r[0] <= 33'(in_point_x) - 33'(in_pivot_x);
      p0_r[1] <= 33'(in_point_y) - 33'(in_pivot_y);
      p0_r[2] <= 33'(in_point_z) - 33'(in_pivot_z);
      k0_r[0] <= in_axis_x; k0_r[1] <= in_axis_y; k0_r[2] <= in_axis_z;
      v0_r[0] <= in_pivot_x; v0_r[1] <= in_pivot_y; v0_r[2] <= in_pivot_z;
      flip0_r <= fl;
      seed_r.x <= rpa_pkg::cval_t'(rpa_pkg::InvGainQ30);
      seed_r.y <= '0;
      seed_r.z <= rpa_pkg::zval_t'($signed({a2, 16'd0}));
    end
  end

  // CORDIC row with side data carried alongside.
  rpa_pkg::cstate_t chain [NS+1];
  logic signed [rpa_pkg::PW-1:0] pd_r [NS][3];
  logic signed [15:0] kd_r [NS][3];
  logic signed [31:0] vd_r [NS][3];
  logic [NS-1:0] fd_r;

  assign chain[0] = seed_r;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    rpa_cordic_cell u_cell (
      .clk(clk), .en(en), .idx(5'(i)), .d_in(chain[i]), .d_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        for (int j = 0; j < 3; j++) begin
          pd_r[i][j] <= (i == 0) ? p0_r[j] : pd_r[(i == 0) ? 0 : i-1][j];
          kd_r[i][j] <= (i == 0) ? k0_r[j] : kd_r[(i == 0) ? 0 : i-1][j];
          vd_r[i][j] <= (i == 0) ? v0_r[j] : vd_r[(i == 0) ? 0 : i-1][j];
        end
        fd_r[i] <= (i == 0) ? flip0_r : fd_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Negate on flip, round Q30 to Q16.
  rpa_pkg::cval_t xf, yf;
  logic signed [rpa_pkg::TW-1:0] cos_v, sin_v;
  always_comb begin
    xf = fd_r[NS-1] ? -chain[NS].x : chain[NS].x;
    yf = fd_r[NS-1] ? -chain[NS].y : chain[NS].y;
    cos_v = rpa_pkg::TW'((xf + 34'sd8192) >>> 14);
    sin_v = rpa_pkg::TW'((yf + 34'sd8192) >>> 14);
  end

  rpa_rodrigues u_comb (
    .clk(clk), .en(en), .cos_v(cos_v), .sin_v(sin_v),
    .p_x(pd_r[NS-1][0]), .p_y(pd_r[NS-1][1]), .p_z(pd_r[NS-1][2]),
    .k_x(kd_r[NS-1][0]), .k_y(kd_r[NS-1][1]), .k_z(kd_r[NS-1][2]),
    .v_x(vd_r[NS-1][0]), .v_y(vd_r[NS-1][1]), .v_z(vd_r[NS-1][2]),
    .r_x(out_rotated_x), .r_y(out_rotated_y), .r_z(out_rotated_z)
  );

  assign out_valid = vld_r[DEPTH-1];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(vld_r))
    else $error("pipeline moved under output stall");

  a_accept_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted beat not tracked");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for rotate_point_3d_about_axis (Rodrigues rotation, CORDIC sin/cos).
// Depends on rpa_pkg and the RTL in rtl/; computes expected rotations in-line.
module tb_top;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic signed [15:0] in_axis_x, in_axis_y, in_axis_z;
  logic signed [31:0] in_pivot_x, in_pivot_y, in_pivot_z;
  logic [15:0] in_angle;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_rotated_x, out_rotated_y, out_rotated_z;

  typedef struct {
    logic signed [31:0] pt [3];
    logic signed [15:0] ax [3];
    logic signed [31:0] pv [3];
    logic [15:0] ang;
  } beat_t;

  typedef struct {
    logic signed [31:0] r [3];
  } rot_t;

  rot_t expected_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  longint cycles = 0;
  int hold_pct = 20;

  localparam longint CycleLimit = 3000000;
  localparam int Latency = rpa_pkg::CordicStages + 5;

  rotate_point_3d_about_axis DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Rounding helpers: add half LSB then arithmetic shift
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                  output longint s);
    longint arct [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    logic flip;
    logic [15:0] a2;
    longint x, y, z, dx, dy;
    flip = (ang >= 16'd16384) && (ang < 16'd49152);
    a2 = flip ? (ang ^ 16'h8000) : ang;
    z = longint'($signed(a2)) * 65536;
    x = rpa_pkg::InvGainQ30;
    y = 0;
    for (int i = 0; i < rpa_pkg::CordicStages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arct[i];
      end else begin
        x += dx; y -= dy; z += arct[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = rnd_shift(x, 14);
    s = rnd_shift(y, 14);
  endfunction

  function automatic rot_t rotate_about_axis(beat_t b);
    rot_t res;
    longint p [3], k [3], q [3], pv [3];
    longint c, s, dot, t, omc;
    for (int j = 0; j < 3; j++) begin
      pv[j] = b.pv[j];
      k[j] = b.ax[j];
      p[j] = longint'(b.pt[j]) - pv[j];
    end
    sin_cos(b.ang, c, s);
    dot = rnd_shift(k[0] * p[0] + k[1] * p[1] + k[2] * p[2], 14);
    omc = 65536 - c;
    t = rnd_shift(dot * omc, 16);
    q[0] = rnd_shift(k[1] * p[2] - k[2] * p[1], 14);
    q[1] = rnd_shift(k[2] * p[0] - k[0] * p[2], 14);
    q[2] = rnd_shift(k[0] * p[1] - k[1] * p[0], 14);
    for (int j = 0; j < 3; j++)
      res.r[j] = 32'(clamp32(rnd_shift(c * p[j], 16) + rnd_shift(k[j] * t, 14)
                 + rnd_shift(s * q[j], 16) + pv[j]));
    return res;
  endfunction

  // Mostly short gaps, an occasional long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(beat_t b);
    int g;
    g = (hold_pct == 0) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= b.pt[0]; in_point_y <= b.pt[1]; in_point_z <= b.pt[2];
    in_axis_x <= b.ax[0]; in_axis_y <= b.ax[1]; in_axis_z <= b.ax[2];
    in_pivot_x <= b.pv[0]; in_pivot_y <= b.pv[1]; in_pivot_z <= b.pv[2];
    in_angle <= b.ang;
    expected_q.push_back(rotate_about_axis(b));
    sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Checker: beat accepted when valid and not stalled
  always @(posedge clk) begin
    rot_t e;
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time,
                 out_rotated_x, out_rotated_y, out_rotated_z);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_rotated_x !== e.r[0]) begin
          $display("%0t: x expected %0d actual %0d", $time, e.r[0], out_rotated_x);
          errors++;
        end
        if (out_rotated_y !== e.r[1]) begin
          $display("%0t: y expected %0d actual %0d", $time, e.r[1], out_rotated_y);
          errors++;
        end
        if (out_rotated_z !== e.r[2]) begin
          $display("%0t: z expected %0d actual %0d", $time, e.r[2], out_rotated_z);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: runs of random stall and quiet stretches
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      g = gap_len();
      if (g > 0 && $urandom_range(0, 99) < hold_pct) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  function automatic logic signed [15:0] unit_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sd16384;
    if (r == 1) return -16'sd16384;
    if (r == 2) return 16'sd0;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int sel, m;
    sel = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) begin
      if (sel < 6) begin
        // moderate coordinates keep most results off saturation
        m = $urandom_range(8, 30);
        b.pt[j] = 32'($signed($urandom) >>> (31 - m));
        b.pv[j] = 32'($signed($urandom) >>> (31 - m));
      end else begin
        b.pt[j] = $urandom;
        b.pv[j] = $urandom;
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      // cardinal axis
      b.ax = '{0, 0, 0};
      b.ax[$urandom_range(0, 2)] = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
    end else if (sel < 8) begin
      for (int j = 0; j < 3; j++) b.ax[j] = unit_comp();
    end else begin
      for (int j = 0; j < 3; j++) b.ax[j] = $urandom;
    end
    b.ang = $urandom;
    return b;
  endfunction

  function automatic beat_t mk(longint px, longint py, longint pz, int ax, int ay,
                               int az, longint vx, longint vy, longint vz, int ang);
    beat_t b;
    b.pt = '{32'(px), 32'(py), 32'(pz)};
    b.ax = '{16'(ax), 16'(ay), 16'(az)};
    b.pv = '{32'(vx), 32'(vy), 32'(vz)};
    b.ang = 16'(ang);
    return b;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // quarter turns, the flip boundaries, zero angle
    send_beat(mk(65536, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
    send_beat(mk(65536, 0, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_beat(mk(65536, 0, 0, 0, 0, 16384, 0, 0, 0, 16383));
    send_beat(mk(65536, 0, 0, 0, 0, 16384, 0, 0, 0, 32768));
    send_beat(mk(65536, 0, 0, 0, 0, 16384, 0, 0, 0, 49151));
    send_beat(mk(65536, 0, 0, 0, 0, 16384, 0, 0, 0, 49152));
    send_beat(mk(65536, 65536, 65536, 16384, 0, 0, 0, 0, 0, 65535));
    send_beat(mk(0, 65536, 0, 0, -16384, 0, 131072, -65536, 7, 8192));
    // extreme coordinates, difference needs 33 bits, saturation
    send_beat(mk(mx, mx, mx, 0, 0, 16384, mn, mn, mn, 16384));
    send_beat(mk(mn, mn, mn, 16384, 0, 0, mx, mx, mx, 32768));
    send_beat(mk(mx, mn, mx, 9459, 9459, 9459, mn, mx, mn, 12345));
    send_beat(mk(mx, mx, mx, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(mn, mn, mn, 0, 0, 0, mx, mx, mx, 0));
    // non-unit axes, out-of-range components
    send_beat(mk(100000, -200000, 300000, 16384, 16384, 16384, 0, 0, 0, 10000));
    send_beat(mk(100000, -200000, 300000, -32768, 32767, -1, 5, 5, 5, 40000));
    send_beat(mk(mx, mx, mx, -32768, -32768, -32768, 0, 0, 0, 20000));
    send_beat(mk(-1, -1, -1, 32767, 32767, 32767, -1, 0, 1, 60000));
    send_beat(mk(1, 1, 1, 0, 0, 0, -1, -1, -1, 16'hffff));
    drop_valid();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      // stretches with no idling on either side
      if (i % 400 == 0) hold_pct = (i % 800 == 0) ? 0 : 25;
      send_beat(rand_beat());
    end
    drop_valid();
    hold_pct = 20;
  endtask

  task automatic test_drain_pause();
    // sender holds off until everything is back, then resumes
    test_random(30);
    wait_drained();
    test_random(30);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_point_x, in_point_y, in_point_z} = '0;
    {in_axis_x, in_axis_y, in_axis_z} = '0;
    {in_pivot_x, in_pivot_y, in_pivot_z} = '0;
    in_angle = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(1800);
    wait_drained();
    $display("Sent %0d beats with random gaps and output stalls; %0d results checked.",
             sent, received);
    if (errors == 0 && expected_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ rotate_point_3d_about_axis.f @@
rtl/rpa_pkg.sv
rtl/rpa_cordic_cell.sv
rtl/rpa_rodrigues.sv
rtl/rotate_point_3d_about_axis.sv
dv/tb_top.sv
